[hdl/hmq_pkg.sv]
// hmq_pkg: command and status codes and the request and response word types
// for the indexed min-heap queue.
// No dependencies.
package hmq_pkg;

   localparam logic [1:0] CMD_PUSH     = 2'd0;
   localparam logic [1:0] CMD_EXTRACT  = 2'd1;
   localparam logic [1:0] CMD_DECREASE = 2'd2;

   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_EXTRACTED = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_ABSENT    = 3'd4;

   localparam int KEY_W = 32;
   localparam int OPN_W = 11;

   typedef struct packed {
      logic [1:0]              cmd;
      logic signed [KEY_W-1:0] key_value;
      logic [OPN_W-1:0]        target_op;
   } req_word_type;

   typedef struct packed {
      logic [2:0]              status;
      logic signed [KEY_W-1:0] min_key;
      logic [OPN_W-1:0]        min_op;
   } rsp_word_type;

endpackage

[hdl/hmq_ram.sv]
// hmq_ram: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
module hmq_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

[hdl/indexed_min_heap_queue_unit.sv]
// indexed_min_heap_queue_unit: indexed binary min-heap with decrease-key.
// Depends on hmq_pkg and hmq_ram.
//
// Usage: drive req_word and pulse start while busy is low; the word is taken
// at that edge and, unless it is answered ST_FULL, gets the next operation
// number. Exactly one response word follows on rsp_word, marked by rsp_strobe
// for a single cycle; the receiver cannot hold it off, so it must capture it
// in that cycle. Words settled at once (numbers exhausted, full heap, empty
// extract, target number not yet issued) answer in the next cycle and leave
// busy low. Otherwise busy stays high while one path of the heap is walked:
//   push          parent read and compare per level, then drop into the hole
//   extract-min   root and last entry reads, then per level a left and, if
//                 present, a right child read; a lone entry ends at the root
//   decrease-key  slot lookup and target read, then the climb or descent;
//                 it ends at the lookup if the target was extracted
// The single read port of the heap RAM sets the pace.
// The response strobe rises in the cycle busy falls.
// Reset clears the counters and the sequencer; the RAMs keep their contents.
// The slot table needs no clearing pass: every operation number writes its
// own entry while it runs, and only numbers already issued are ever looked up.
module indexed_min_heap_queue_unit #(
   parameter int CAPACITY = 256,
   parameter int MAX_OPS  = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hmq_pkg::req_word_type req_word,
   output logic                 rsp_strobe,
   output hmq_pkg::rsp_word_type rsp_word
);
   import hmq_pkg::*;

   localparam int SW  = $clog2(CAPACITY);       // heap slot index
   localparam int CW  = $clog2(CAPACITY + 1);   // heap fill count
   localparam int OW  = $clog2(MAX_OPS);        // stored owner number
   localparam int OCW = $clog2(MAX_OPS + 1);    // operation counter
   localparam int TW  = (OCW > OPN_W) ? OCW : OPN_W;
   localparam int XW  = SW + 2;                 // child index arithmetic
   localparam int HW  = KEY_W + OW;             // heap entry: key, owner
   localparam int PW  = SW + 1;                 // slot entry: valid, slot

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_UP   = 4'd1;  // climb: issue parent read
   localparam logic [3:0] S_UPW  = 4'd2;  // climb: compare with parent
   localparam logic [3:0] S_DN   = 4'd3;  // descend: issue left read
   localparam logic [3:0] S_DNL  = 4'd4;  // left child back
   localparam logic [3:0] S_DNR  = 4'd5;  // right child back
   localparam logic [3:0] S_EX0  = 4'd6;  // root back
   localparam logic [3:0] S_EX1  = 4'd7;  // last entry back
   localparam logic [3:0] S_DK0  = 4'd8;  // slot lookup back
   localparam logic [3:0] S_DK1  = 4'd9;  // target entry back
   localparam logic [3:0] S_FIN  = 4'd10; // drop moving entry into hole

   // control state
   logic [3:0]     state_ff, state_in;
   logic [OCW-1:0] opcnt_ff, opcnt_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   // payload
   logic [SW-1:0]           idx_ff, idx_in;
   logic signed [KEY_W-1:0] cur_key_ff, cur_key_in;
   logic [OW-1:0]           cur_own_ff, cur_own_in;
   logic signed [KEY_W-1:0] lkey_ff, lkey_in;
   logic [OW-1:0]           lown_ff, lown_in;
   rsp_word_type            rsp_ff, rsp_in;

   // RAM ports
   logic          h_we, h_re, p_we, p_re;
   logic [SW-1:0] h_waddr, h_raddr;
   logic [HW-1:0] h_wdata, h_rdata;
   logic [OW-1:0] p_waddr, p_raddr;
   logic [PW-1:0] p_wdata, p_rdata;

   hmq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
      .clock, .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
      .rd_en(h_re), .rd_addr(h_raddr), .rd_data(h_rdata)
   );

   hmq_ram #(.WIDTH(PW), .DEPTH(MAX_OPS)) u_slot (
      .clock, .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
      .rd_en(p_re), .rd_addr(p_raddr), .rd_data(p_rdata)
   );

   logic signed [KEY_W-1:0] rd_key;
   logic [OW-1:0]           rd_own;
   logic [XW-1:0]           lidx, ridx, cnt_x;
   logic [SW-1:0]           pidx;
   logic [TW-1:0]           tgt, tgt_m1;
   logic                    tgt_ok, r_ok;
   logic signed [KEY_W-1:0] ch_key;
   logic [OW-1:0]           ch_own;
   logic [XW-1:0]           ch_idx;

   assign rd_key = h_rdata[HW-1:OW];
   assign rd_own = h_rdata[OW-1:0];
   assign lidx   = {1'b0, idx_ff, 1'b1};
   assign ridx   = lidx + XW'(1);
   assign cnt_x  = XW'(count_ff);
   assign r_ok   = ridx < cnt_x;
   assign pidx   = SW'((idx_ff - SW'(1)) >> 1);
   assign tgt    = TW'(req_word.target_op);
   assign tgt_m1 = tgt - TW'(1);
   // target must be a number already issued before this one
   assign tgt_ok = (tgt != '0) && (tgt_m1 < TW'(opcnt_ff));

   // child chosen for the descent: right on a tie
   always_comb begin
      ch_key = rd_key;
      ch_own = rd_own;
      ch_idx = lidx;
      if (state_ff == S_DNR) begin
         if (lkey_ff < rd_key) begin
            ch_key = lkey_ff;
            ch_own = lown_ff;
         end else begin
            ch_idx = ridx;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      opcnt_in     = opcnt_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      idx_in       = idx_ff;
      cur_key_in   = cur_key_ff;
      cur_own_in   = cur_own_ff;
      lkey_in      = lkey_ff;
      lown_in      = lown_ff;
      rsp_in       = rsp_ff;
      h_we = 1'b0; h_waddr = idx_ff; h_wdata = {cur_key_ff, cur_own_ff};
      h_re = 1'b0; h_raddr = '0;
      p_we = 1'b0; p_waddr = cur_own_ff; p_wdata = {1'b1, idx_ff};
      p_re = 1'b0; p_raddr = OW'(tgt_m1);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in     = '{status: ST_DONE, min_key: '0, min_op: '0};
               cur_key_in = req_word.key_value;
               if (opcnt_ff == OCW'(MAX_OPS)) begin
                  rsp_in.status = ST_FULL;
                  rsp_valid_in  = 1'b1;
               end else if (req_word.cmd == CMD_PUSH) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     rsp_in.status = ST_FULL;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     opcnt_in   = opcnt_ff + OCW'(1);
                     cur_own_in = OW'(opcnt_ff);
                     idx_in     = SW'(count_ff);
                     count_in   = count_ff + CW'(1);
                     state_in   = S_UP;
                  end
               end else begin
                  // extract or decrease: this number is never a push
                  opcnt_in = opcnt_ff + OCW'(1);
                  p_we     = 1'b1;
                  p_waddr  = OW'(opcnt_ff);
                  p_wdata  = '0;
                  if (req_word.cmd == CMD_EXTRACT) begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        rsp_in.status = ST_EXTRACTED;
                        h_re     = 1'b1;
                        h_raddr  = '0;
                        state_in = S_EX0;
                     end
                  end else if (tgt_ok) begin
                     p_re     = 1'b1;
                     state_in = S_DK0;
                  end else begin
                     rsp_in.status = ST_ABSENT;
                     rsp_valid_in  = 1'b1;
                  end
               end
            end
         end
         S_EX0: begin
            rsp_in.min_key = rd_key;
            rsp_in.min_op  = OPN_W'(TW'(rd_own) + TW'(1));
            p_we    = 1'b1;
            p_waddr = rd_own;
            p_wdata = '0;
            count_in = count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               h_re     = 1'b1;
               h_raddr  = SW'(count_ff - CW'(1));
               state_in = S_EX1;
            end
         end
         S_EX1: begin
            cur_key_in = rd_key;
            cur_own_in = rd_own;
            idx_in     = '0;
            state_in   = S_DN;
         end
         S_DK0: begin
            if (p_rdata[SW] && (CW'(p_rdata[SW-1:0]) < count_ff)) begin
               h_re     = 1'b1;
               h_raddr  = p_rdata[SW-1:0];
               idx_in   = p_rdata[SW-1:0];
               state_in = S_DK1;
            end else begin
               rsp_in.status = ST_ABSENT;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DK1: begin
            cur_own_in = rd_own;
            state_in   = (rd_key < cur_key_ff) ? S_DN : S_UP;
         end
         S_UP: begin
            if (idx_ff == '0) begin
               state_in = S_FIN;
            end else begin
               h_re     = 1'b1;
               h_raddr  = pidx;
               state_in = S_UPW;
            end
         end
         S_UPW: begin
            if (cur_key_ff < rd_key) begin
               h_we     = 1'b1;
               h_wdata  = h_rdata;
               p_we     = 1'b1;
               p_waddr  = rd_own;
               idx_in   = pidx;
               state_in = S_UP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DN: begin
            if (lidx >= cnt_x) begin
               state_in = S_FIN;
            end else begin
               h_re     = 1'b1;
               h_raddr  = SW'(lidx);
               state_in = S_DNL;
            end
         end
         S_DNL, S_DNR: begin
            if (state_ff == S_DNL && r_ok) begin
               lkey_in  = rd_key;
               lown_in  = rd_own;
               h_re     = 1'b1;
               h_raddr  = SW'(ridx);
               state_in = S_DNR;
            end else if (cur_key_ff < ch_key) begin
               state_in = S_FIN;
            end else begin
               h_we     = 1'b1;
               h_wdata  = {ch_key, ch_own};
               p_we     = 1'b1;
               p_waddr  = ch_own;
               idx_in   = SW'(ch_idx);
               state_in = S_DN;
            end
         end
         S_FIN: begin
            h_we         = 1'b1;
            p_we         = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         opcnt_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         opcnt_ff     <= opcnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cur_key_ff <= cur_key_in;
      cur_own_ff <= cur_own_in;
      lkey_ff    <= lkey_in;
      lown_ff    <= lown_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;
endmodule

[hdl/hmq_checker.sv]
// hmq_checker: port-level checks of the indexed min-heap queue, bound to
// the top level. Depends on hmq_pkg and indexed_min_heap_queue_unit.
module hmq_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_strobe,
   input hmq_pkg::rsp_word_type rsp_word
);
   import hmq_pkg::*;

   // an accepted word either answers at once or makes the unit busy
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy != rsp_strobe))
      else $error("accepted word neither answered nor busy");

   // end of a walk always delivers its response
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("walk ended without response");

   // no response while a walk is still going
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("response while busy");

   // min fields are zero unless a key was extracted
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status != ST_EXTRACTED)
         |-> (rsp_word.min_key == '0 && rsp_word.min_op == '0))
      else $error("min fields set without extraction");
endmodule

bind indexed_min_heap_queue_unit hmq_checker u_hmq_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_strobe(rsp_strobe),
   .rsp_word(rsp_word)
);

[tb/testbench.sv]
// testbench: self-checking regression for indexed_min_heap_queue_unit.
// Depends on hmq_pkg and the unit; a built-in heap predictor checks every response word.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hmq_pkg::*;

   localparam int CAP       = 256;
   localparam int OPS_LIMIT = 1024;
   localparam int LIMIT     = 400000;
   // Unnamed fourth command code; the unit treats it as decrease-key.
   localparam logic [1:0] CMD_ALIAS = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   indexed_min_heap_queue_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   always #10 clock = ~clock;

   // ---- predictor state: heap entries, position map, counters ----
   logic signed [31:0] heap_key [CAP];
   int                 heap_own [CAP];
   int                 pos_of   [OPS_LIMIT];
   bit                 in_heap  [OPS_LIMIT];
   int                 heap_size, ops_issued;

   req_word_type pending_words [$];
   rsp_word_type awaited_rsp [$];
   int errors, cycles, gap;

   task automatic swap_slots(int a, int b);
      logic signed [31:0] k;
      int o;
      k = heap_key[a]; o = heap_own[a];
      heap_key[a] = heap_key[b]; heap_own[a] = heap_own[b];
      heap_key[b] = k; heap_own[b] = o;
      pos_of[heap_own[a]] = a;
      pos_of[heap_own[b]] = b;
   endtask

   task automatic climb(int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!(heap_key[i] < heap_key[p])) break;
         swap_slots(i, p);
         i = p;
      end
   endtask

   // Equal children: right one wins; equal to child still moves down.
   task automatic descend(int i);
      int l, j;
      while (2 * i + 1 < heap_size) begin
         l = 2 * i + 1;
         j = l;
         if (l + 1 < heap_size && !(heap_key[l] < heap_key[l + 1])) j = l + 1;
         if (heap_key[i] < heap_key[j]) break;
         swap_slots(i, j);
         i = j;
      end
   endtask

   // Apply one accepted word to the predicted heap, queue the expected answer.
   task automatic heap_apply(req_word_type w);
      rsp_word_type r;
      int op, tgt, s, last;
      logic signed [31:0] old;
      r = '0;
      tgt = int'(w.target_op);
      if (ops_issued >= OPS_LIMIT) begin
         r.status = ST_FULL;
      end else if (w.cmd == CMD_PUSH) begin
         if (heap_size >= CAP) begin
            r.status = ST_FULL;
         end else begin
            op = ops_issued++;
            heap_key[heap_size] = w.key_value;
            heap_own[heap_size] = op;
            pos_of[op] = heap_size;
            in_heap[op] = 1'b1;
            heap_size++;
            climb(heap_size - 1);
            r.status = ST_DONE;
         end
      end else if (w.cmd == CMD_EXTRACT) begin
         op = ops_issued++;
         in_heap[op] = 1'b0;
         if (heap_size == 0) begin
            r.status = ST_EMPTY;
         end else begin
            last = heap_size - 1;
            r.status  = ST_EXTRACTED;
            r.min_key = heap_key[0];
            r.min_op  = OPN_W'(heap_own[0] + 1);
            in_heap[heap_own[0]] = 1'b0;
            if (last != 0) begin
               heap_key[0] = heap_key[last];
               heap_own[0] = heap_own[last];
               pos_of[heap_own[0]] = 0;
            end
            heap_size = last;
            descend(0);
         end
      end else begin
         op = ops_issued++;
         in_heap[op] = 1'b0;
         if (tgt >= 1 && tgt - 1 < op && in_heap[tgt - 1] && pos_of[tgt - 1] < heap_size)
         begin
            s = pos_of[tgt - 1];
            old = heap_key[s];
            heap_key[s] = w.key_value;
            if (old < w.key_value) descend(s);
            else climb(s);
            r.status = ST_DONE;
         end else begin
            r.status = ST_ABSENT;
         end
      end
      awaited_rsp = {awaited_rsp, r};
   endtask

   task automatic report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   // ---- driver: at most one start assignment per edge ----
   always @(posedge clock) begin
      bit nxt;
      int pick;
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // word held until taken
      end else begin
         if (start) heap_apply(req_word);
         nxt = 1'b0;
         if (gap > 0) begin
            gap--;
         end else if (pending_words.size() > 0) begin
            nxt = 1'b1;
            req_word <= pending_words.pop_front();
            pick = $urandom_range(99);
            if (pick < 40)      gap = 0;
            else if (pick < 90) gap = $urandom_range(3, 1);
            else if (pick < 98) gap = $urandom_range(15, 4);
            else                gap = $urandom_range(80, 30);
         end
         start <= nxt;
      end
   end

   // ---- monitor: response words cannot be stalled ----
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_strobe) begin
         if (awaited_rsp.size() == 0) begin
            report($sformatf("unexpected response word %p", rsp_word));
         end else begin
            e = awaited_rsp.pop_front();
            if (rsp_word.status !== e.status)
               report($sformatf("status %0d, want %0d", rsp_word.status, e.status));
            if (rsp_word.min_key !== e.min_key)
               report($sformatf("min_key %0d, want %0d", rsp_word.min_key, e.min_key));
            if (rsp_word.min_op !== e.min_op)
               report($sformatf("min_op %0d, want %0d", rsp_word.min_op, e.min_op));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("indexed_min_heap_queue_unit regression: fail");
         $finish;
      end
   end

   // ---- stimulus generation ----
   int push_ops [$];   // op numbers believed to be pushes (generator view)
   int gen_ops;

   function automatic req_word_type mk(logic [1:0] c, logic [31:0] k, int t);
      req_word_type w;
      w.cmd = c; w.key_value = k; w.target_op = t[10:0];
      return w;
   endfunction

   function automatic logic [31:0] rand_key();
      case ($urandom_range(3))
         0:       return $urandom_range(7);          // tie-prone
         1:       return 32'd0 - $urandom_range(7);
         default: return $urandom;
      endcase
   endfunction

   task automatic add(req_word_type w);
      pending_words = {pending_words, w};
      if (w.cmd == CMD_PUSH) push_ops = {push_ops, gen_ops + 1};
      gen_ops++;
   endtask

   task automatic add_random(int push_pct);
      int r, t;
      r = $urandom_range(99);
      if (r < push_pct) begin
         add(mk(CMD_PUSH, rand_key(), $urandom_range(2047)));
      end else if (r < push_pct + (100 - push_pct) / 2) begin
         add(mk(CMD_EXTRACT, $urandom, $urandom_range(2047)));
      end else begin
         if (push_ops.size() > 0 && $urandom_range(9) < 8)
            t = push_ops[$urandom_range(push_ops.size() - 1)];
         else
            t = $urandom_range(2047);
         add(mk($urandom_range(9) == 0 ? CMD_ALIAS : CMD_DECREASE, rand_key(), t));
      end
   endtask

   initial begin
      errors = 0; cycles = 0; gap = 0; gen_ops = 0;
      heap_size = 0; ops_issued = 0;
      foreach (in_heap[i]) in_heap[i] = 1'b0;

      // Directed: empty extract, absent targets, key extremes, ties,
      // both sift directions, alias command, all target bits.
      add(mk(CMD_EXTRACT, 32'h0, 0));                 // op1 empty
      add(mk(CMD_DECREASE, 32'h5, 0));                // op2 target zero
      add(mk(CMD_DECREASE, 32'h5, 3));                // op3 targets itself
      add(mk(CMD_PUSH, 32'h7FFF_FFFF, 0));            // op4
      add(mk(CMD_PUSH, 32'h8000_0000, 2047));         // op5
      add(mk(CMD_PUSH, 32'h0, 0));                    // op6
      add(mk(CMD_PUSH, 32'hFFFF_FFFF, 0));            // op7
      add(mk(CMD_PUSH, 32'h3, 0));                    // op8
      add(mk(CMD_PUSH, 32'h3, 0));                    // op9 tie
      add(mk(CMD_DECREASE, 32'h1, 1));                // op10 targets extract
      add(mk(CMD_DECREASE, 32'h1, 2047));             // op11 beyond range
      add(mk(CMD_DECREASE, 32'h1, 30));               // op12 later op
      add(mk(CMD_ALIAS, 32'h7FFF_FFFF, 5));           // op13 raise: sink
      add(mk(CMD_DECREASE, 32'h8000_0000, 4));        // op14 lower: climb
      add(mk(CMD_DECREASE, 32'h3, 6));                // op15 tie with siblings
      add(mk(CMD_PUSH, 32'h3, 0));                    // op16
      for (int i = 0; i < 7; i++) add(mk(CMD_EXTRACT, 32'h0, 0));
      add(mk(CMD_DECREASE, 32'h2, 4));                // extracted push
      add(mk(CMD_PUSH, 32'h5555_AAAA, 1365));

      for (int i = 0; i < 200; i++) add_random(45);
      // Fill the heap past capacity, then drain part of it.
      for (int i = 0; i < 290; i++) add(mk(CMD_PUSH, rand_key(), 0));
      for (int i = 0; i < 85; i++) add_random(25);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      wait (pending_words.size() == 0 && !start);
      wait (awaited_rsp.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0 && awaited_rsp.size() == 0)
         $display("indexed_min_heap_queue_unit regression: pass");
      else
         $display("indexed_min_heap_queue_unit regression: fail");
      $finish;
   end
endmodule
